[sv/length_prefixed_csv_record_splitter_top_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the CSV record splitter
// Immediate-implication and next-cycle property wrappers on clk / rst_n.
// ----------------------------------------------------------------------------
`ifndef LENGTH_PREFIXED_CSV_RECORD_SPLITTER_TOP_ASSERT_SVH
`define LENGTH_PREFIXED_CSV_RECORD_SPLITTER_TOP_ASSERT_SVH

`ifndef SYNTH
// ante true implies cons in the same cycle
`define LPCSV_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// ante true implies cons in the next cycle
`define LPCSV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LPCSV_ASSERT_NOW(label, ante, cons, msg)
`define LPCSV_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

[sv/lpcsv_pkg.sv]
// ----------------------------------------------------------------------------
// lpcsv_pkg
// Shared constants and the result word type of the CSV record splitter.
// ----------------------------------------------------------------------------
package lpcsv_pkg;

  // record length register width (8..32)
  localparam int LENGTH_WIDTH = 32;

  // result queue geometry
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = FIFO_AW + 1;

  // byte codes
  localparam logic [7:0] QUOTE_BYTE = 8'h22;
  localparam logic [7:0] ASCII_ZERO = 8'h30;
  localparam logic [7:0] ASCII_NINE = 8'h39;

  localparam logic [7:0] FIELD_MAX = 8'd255;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_DELIMITER     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LENGTH_FORMAT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LENGTH_DIGITS = 2'd2;

  // length format codes
  localparam logic FMT_ASCII  = 1'b0;
  localparam logic FMT_BINARY = 1'b1;

  // register reset values
  localparam logic [7:0] DELIMITER_RST     = 8'd44;
  localparam logic       LENGTH_FORMAT_RST = FMT_ASCII;
  localparam logic [2:0] LENGTH_DIGITS_RST = 3'd2;

  // prefix length limits
  localparam logic [2:0] DIGITS_MIN = 3'd1;
  localparam logic [2:0] DIGITS_MAX = 3'd4;

  // one result word
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       field_end;
    logic       record_end;
    logic [7:0] field_index;
    logic       prefix_error;
  } result_t;

endpackage

[sv/lpcsv_res_fifo.sv]
// ----------------------------------------------------------------------------
// lpcsv_res_fifo
// Small result queue: takes zero, one or two words per cycle, gives one.
// ----------------------------------------------------------------------------
module lpcsv_res_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [1:0]           push_cnt,
  input  lpcsv_pkg::result_t   push_word0,
  input  lpcsv_pkg::result_t   push_word1,
  input  logic                 pop,
  output lpcsv_pkg::result_t   head_word,
  output logic                 not_empty,
  output logic                 room_for_two
);

  lpcsv_pkg::result_t mem [lpcsv_pkg::FIFO_DEPTH];

  logic [lpcsv_pkg::FIFO_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [lpcsv_pkg::FIFO_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [lpcsv_pkg::FIFO_CW-1:0] count_r, count_nxt;
  logic [lpcsv_pkg::FIFO_AW-1:0] wr_ptr_p1;
  logic                          do_pop;

  assign not_empty    = (count_r != '0);
  assign room_for_two = (count_r <= lpcsv_pkg::FIFO_CW'(lpcsv_pkg::FIFO_DEPTH - 2));
  assign head_word    = mem[rd_ptr_r];
  assign do_pop       = pop && not_empty;
  assign wr_ptr_p1    = wr_ptr_r + lpcsv_pkg::FIFO_AW'(1);

  // pointer and fill level update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + lpcsv_pkg::FIFO_AW'(push_cnt);
    rd_ptr_nxt = do_pop ? rd_ptr_r + lpcsv_pkg::FIFO_AW'(1) : rd_ptr_r;
    count_nxt  = count_r + lpcsv_pkg::FIFO_CW'(push_cnt)
                 - lpcsv_pkg::FIFO_CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage: second word lands one slot after the first
  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem[wr_ptr_r] <= push_word0;
    end
    if (push_cnt == 2'd2) begin
      mem[wr_ptr_p1] <= push_word1;
    end
  end

endmodule

[sv/length_prefixed_csv_record_splitter_top.sv]
// ----------------------------------------------------------------------------
// length_prefixed_csv_record_splitter_top
// Splits length-prefixed records into CSV fields, one stream byte per word.
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   in      | in_valid, in_ready, in_data_byte        | sink
//   out     | out_valid, out_ready, out_out_byte ...  | source
//   cfg     | cfg_we, cfg_index, cfg_wdata            | sink
//
// One input word per clock while in_ready is high; each word is parsed in
// the cycle it is taken and yields 0, 1 or 2 result words into a 4-deep
// result queue. in_ready stays high while the queue has room for two words,
// so a steady one-in/one-out flow never stalls, but a trailing delimiter can.
// Reset (rst_n low at a clock edge) clears parser and queue, resets config.
// ----------------------------------------------------------------------------
`include "length_prefixed_csv_record_splitter_top_assert.svh"

module length_prefixed_csv_record_splitter_top (
  input  logic                              clk,
  input  logic                              rst_n,
  // input channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [7:0]                        in_data_byte,
  // result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [7:0]                        out_out_byte,
  output logic                              out_byte_valid,
  output logic                              out_field_end,
  output logic                              out_record_end,
  output logic [7:0]                        out_field_index,
  output logic                              out_prefix_error,
  // configuration
  input  logic                              cfg_we,
  input  logic [lpcsv_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [7:0]                        cfg_wdata
);

  localparam int LW = lpcsv_pkg::LENGTH_WIDTH;

  typedef enum logic [1:0] {
    Q_UNQUOTED = 2'd0,
    Q_QUOTED   = 2'd1,
    Q_SEEN     = 2'd2
  } quote_t;

  // config registers
  logic [7:0] delimiter_r;
  logic       length_format_r;
  logic [2:0] length_digits_r;

  // parser state
  logic          in_body_r,       in_body_nxt;
  logic [2:0]    prefix_count_r,  prefix_count_nxt;
  logic [LW-1:0] record_length_r, record_length_nxt;
  logic [LW-1:0] byte_count_r,    byte_count_nxt;
  quote_t        quote_r,         quote_nxt;
  logic [7:0]    field_count_r,   field_count_nxt;

  // datapath helpers
  logic             in_fire;
  logic [2:0]       digits_eff;
  logic             is_digit;
  logic [LW+3:0]    rl_ext;
  logic [LW+3:0]    rl_dec;
  logic [LW-1:0]    rl_ascii;
  logic [31:0]      bin_word;
  logic [LW-1:0]    rl_bin;
  logic [LW-1:0]    rl_cand;
  logic [2:0]       pc_inc;
  logic [LW:0]      bc_inc;
  logic             last;
  logic [7:0]       fc_inc;
  logic             restart;

  // result queue interface
  logic [1:0]          push_cnt;
  lpcsv_pkg::result_t  res0, res1;
  lpcsv_pkg::result_t  head;
  logic                q_not_empty;
  logic                q_room;

  assign in_ready = q_room;
  assign in_fire  = in_valid && in_ready;

  // config writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delimiter_r     <= lpcsv_pkg::DELIMITER_RST;
      length_format_r <= lpcsv_pkg::LENGTH_FORMAT_RST;
      length_digits_r <= lpcsv_pkg::LENGTH_DIGITS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lpcsv_pkg::CFG_DELIMITER:     delimiter_r     <= cfg_wdata;
        lpcsv_pkg::CFG_LENGTH_FORMAT: length_format_r <= cfg_wdata[0];
        lpcsv_pkg::CFG_LENGTH_DIGITS: length_digits_r <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  // prefix arithmetic
  always_comb begin
    if (length_digits_r < lpcsv_pkg::DIGITS_MIN) begin
      digits_eff = lpcsv_pkg::DIGITS_MIN;
    end else if (length_digits_r > lpcsv_pkg::DIGITS_MAX) begin
      digits_eff = lpcsv_pkg::DIGITS_MAX;
    end else begin
      digits_eff = length_digits_r;
    end
    is_digit = (in_data_byte >= lpcsv_pkg::ASCII_ZERO) &&
               (in_data_byte <= lpcsv_pkg::ASCII_NINE);
    // length * 10 + digit, saturating
    rl_ext   = {4'b0000, record_length_r};
    rl_dec   = (rl_ext << 3) + (rl_ext << 1) + (LW+4)'(in_data_byte[3:0]);
    rl_ascii = (|rl_dec[LW+3:LW]) ? {LW{1'b1}} : rl_dec[LW-1:0];
    // little-endian byte insert
    bin_word = 32'(in_data_byte) << {prefix_count_r[1:0], 3'b000};
    rl_bin   = record_length_r | bin_word[LW-1:0];
    rl_cand  = (length_format_r == lpcsv_pkg::FMT_BINARY) ? rl_bin : rl_ascii;
    pc_inc   = prefix_count_r + 3'd1;
    // body counters
    bc_inc   = {1'b0, byte_count_r} + (LW+1)'(1);
    last     = (bc_inc >= {1'b0, record_length_r});
    fc_inc   = (field_count_r == lpcsv_pkg::FIELD_MAX) ? field_count_r
                                                       : field_count_r + 8'd1;
  end

  // per-word parse: next state and up to two result words
  always_comb begin
    in_body_nxt       = in_body_r;
    prefix_count_nxt  = prefix_count_r;
    record_length_nxt = record_length_r;
    byte_count_nxt    = byte_count_r;
    quote_nxt         = quote_r;
    field_count_nxt   = field_count_r;
    restart           = 1'b0;
    push_cnt          = 2'd0;
    res0              = '0;
    res1              = '0;

    if (in_fire) begin
      if (!in_body_r) begin
        // length prefix
        if ((length_format_r == lpcsv_pkg::FMT_ASCII) && !is_digit) begin
          restart           = 1'b1;
          res0.prefix_error = 1'b1;
          push_cnt          = 2'd1;
        end else if (pc_inc >= digits_eff) begin
          if (rl_cand == '0) begin
            // empty record
            restart         = 1'b1;
            res0.field_end  = 1'b1;
            res0.record_end = 1'b1;
            push_cnt        = 2'd1;
          end else begin
            in_body_nxt       = 1'b1;
            prefix_count_nxt  = '0;
            record_length_nxt = rl_cand;
            byte_count_nxt    = '0;
            quote_nxt         = Q_UNQUOTED;
            field_count_nxt   = '0;
          end
        end else begin
          prefix_count_nxt  = pc_inc;
          record_length_nxt = rl_cand;
        end
      end else begin
        // record body
        logic emit;
        logic ended;
        emit  = 1'b0;
        ended = 1'b0;
        unique case (quote_r)
          Q_UNQUOTED: begin
            if (in_data_byte == delimiter_r) begin
              ended = 1'b1;
            end else if (in_data_byte == lpcsv_pkg::QUOTE_BYTE) begin
              quote_nxt = Q_QUOTED;
            end else begin
              emit = 1'b1;
            end
          end
          Q_QUOTED: begin
            if (in_data_byte == lpcsv_pkg::QUOTE_BYTE) begin
              quote_nxt = Q_SEEN;
            end else begin
              emit = 1'b1;
            end
          end
          Q_SEEN: begin
            if (in_data_byte == delimiter_r) begin
              ended = 1'b1;
            end else if (in_data_byte == lpcsv_pkg::QUOTE_BYTE) begin
              emit      = 1'b1;
              quote_nxt = Q_QUOTED;
            end else begin
              quote_nxt = Q_UNQUOTED;
            end
          end
          default: quote_nxt = Q_UNQUOTED;
        endcase

        byte_count_nxt = bc_inc[LW-1:0];
        res0.field_index = field_count_r;

        if (ended) begin
          res0.field_end  = 1'b1;
          quote_nxt       = Q_UNQUOTED;
          field_count_nxt = fc_inc;
          push_cnt        = 2'd1;
          if (last) begin
            // trailing delimiter: empty final field
            res1.field_end   = 1'b1;
            res1.record_end  = 1'b1;
            res1.field_index = fc_inc;
            push_cnt         = 2'd2;
          end
        end else if (emit) begin
          res0.out_byte   = in_data_byte;
          res0.byte_valid = 1'b1;
          res0.field_end  = last;
          res0.record_end = last;
          push_cnt        = 2'd1;
        end else if (last) begin
          res0.field_end  = 1'b1;
          res0.record_end = 1'b1;
          push_cnt        = 2'd1;
        end
        restart = last;
      end
    end

    // back to prefix hunt
    if (restart) begin
      in_body_nxt       = 1'b0;
      prefix_count_nxt  = '0;
      record_length_nxt = '0;
      byte_count_nxt    = '0;
      quote_nxt         = Q_UNQUOTED;
      field_count_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_body_r       <= 1'b0;
      prefix_count_r  <= '0;
      record_length_r <= '0;
      byte_count_r    <= '0;
      quote_r         <= Q_UNQUOTED;
      field_count_r   <= '0;
    end else begin
      in_body_r       <= in_body_nxt;
      prefix_count_r  <= prefix_count_nxt;
      record_length_r <= record_length_nxt;
      byte_count_r    <= byte_count_nxt;
      quote_r         <= quote_nxt;
      field_count_r   <= field_count_nxt;
    end
  end

  // result queue
  lpcsv_res_fifo u_res_fifo (
    .clk          (clk),
    .rst_n        (rst_n),
    .push_cnt     (push_cnt),
    .push_word0   (res0),
    .push_word1   (res1),
    .pop          (out_ready),
    .head_word    (head),
    .not_empty    (q_not_empty),
    .room_for_two (q_room)
  );

  assign out_valid        = q_not_empty;
  assign out_out_byte     = head.out_byte;
  assign out_byte_valid   = head.byte_valid;
  assign out_field_end    = head.field_end;
  assign out_record_end   = head.record_end;
  assign out_field_index  = head.field_index;
  assign out_prefix_error = head.prefix_error;

  // checks
  `LPCSV_ASSERT_NOW(a_rec_end_closes_field, out_valid && out_record_end,
                    out_field_end, "record end without field end")
  `LPCSV_ASSERT_NOW(a_prefix_err_clean, out_valid && out_prefix_error,
                    !out_byte_valid && !out_field_end && !out_record_end &&
                    (out_field_index == 8'd0),
                    "prefix error word carries other fields")
  `LPCSV_ASSERT_NEXT(a_idle_holds_state, !in_fire,
                     $stable(in_body_r) && $stable(byte_count_r) &&
                     $stable(field_count_r),
                     "parser state moved without an input word")
  `LPCSV_ASSERT_NOW(a_two_only_at_end, push_cnt == 2'd2, last && in_body_r,
                    "two result words outside a record end")

endmodule
